// ===== hdl/rlc_pkg.sv =====
`timescale 1ns / 1ps

package rlc_pkg;

	// one input request
	typedef struct packed {
		logic        kind;
		logic [3:0]  command_code;
		logic [24:0] payload;
		logic [31:0] now_ms;
	} request_t;

	// one result
	typedef struct packed {
		logic        status;
		logic        update_valid;
		logic [15:0] red_duty;
		logic [15:0] green_duty;
		logic [15:0] blue_duty;
		logic [15:0] cool_duty;
		logic [15:0] warm_duty;
		logic        heartbeat;
		logic        lamp_on;
	} result_t;

	// request kinds and command codes
	localparam logic       KIND_TICK   = 1'b0;
	localparam logic [3:0] CMD_TOGGLE  = 4'd0;
	localparam logic [3:0] CMD_ON      = 4'd1;
	localparam logic [3:0] CMD_OFF     = 4'd2;
	localparam logic [3:0] CMD_HUE     = 4'd3;
	localparam logic [3:0] CMD_SAT     = 4'd4;
	localparam logic [3:0] CMD_VAL     = 4'd5;
	localparam logic [3:0] CMD_RED     = 4'd6;
	localparam logic [3:0] CMD_GREEN   = 4'd7;
	localparam logic [3:0] CMD_BLUE    = 4'd8;
	localparam logic [3:0] CMD_WBRIGHT = 4'd9;
	localparam logic [3:0] CMD_WRATIO  = 4'd10;

	// configuration register indexes
	localparam logic REG_AUTO_OFF  = 1'b0;
	localparam logic REG_HEARTBEAT = 1'b1;

	// decoded operation handed from front to back
	typedef enum logic [3:0] {
		OP_TOGGLE, OP_ON, OP_OFF, OP_HUE, OP_SAT, OP_VAL, OP_RED, OP_GREEN,
		OP_BLUE, OP_WBRIGHT, OP_WRATIO, OP_INVALID, OP_TICK
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [24:0] payload;
		logic [31:0] now_ms;
	} job_t;

	typedef struct packed {
		logic [31:0] auto_off_ms;
		logic        heartbeat_enable;
	} cfg_t;

endpackage

// ===== hdl/rgbw_light_controller.sv =====
`timescale 1ns / 1ps

// RGBW lamp controller. Requests (commands and millisecond ticks) are pushed
// into a two-entry queue and worked off one at a time by a sequencer with a
// shared two-pass multiplier; each request gives exactly one result, which
// waits in an output register while the next request is already taken.
// A simple command needs only the execute step and an out-of-range HSV
// setting stops at the range check; a tick that emits duties forms the cool
// brightness product and, for a ratio below one, the warm one; hue, saturation
// and value commands run the hue reduction loop and three two-pass products
// (C, X and the reciprocal divide by sixty).
// While a result waits unpopped the sequencer holds in its last step.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while the block is idle, unchecked by the block itself.
module rgbw_light_controller #(
	parameter int HEARTBEAT_PERIOD_MS = 3000,
	parameter int FRAC_BITS           = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rlc_pkg::request_t request,
	output logic              empty,
	input  logic              pop,
	output rlc_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_wdata
);

	rlc_pkg::cfg_t cfg_q;
	rlc_pkg::job_t job;
	logic          job_valid, job_take, res_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rlc_pkg::REG_AUTO_OFF:  cfg_q.auto_off_ms      <= cfg_wdata;
				rlc_pkg::REG_HEARTBEAT: cfg_q.heartbeat_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	rlc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	rlc_back #(
		.HB_MS (HEARTBEAT_PERIOD_MS),
		.F     (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job),
		.res_valid (res_valid),
		.res_pop   (pop),
		.res       (result)
	);

	assign empty = !res_valid;

`ifndef SYNTHESIS
	// a lamp that is off drives no duty
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.lamp_on) |-> (result.red_duty == 16'd0 &&
		result.green_duty == 16'd0 && result.blue_duty == 16'd0 &&
		result.cool_duty == 16'd0 && result.warm_duty == 16'd0))
		else $error("duty nonzero with lamp off");
	// heartbeats only while on
	a_hb_on: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.heartbeat) |-> result.lamp_on)
		else $error("heartbeat with lamp off");
	// an invalid command never carries an update
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.status && (result.update_valid || result.heartbeat)))
		else $error("invalid command with tick fields");
	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed before pop");
`endif

endmodule

// ===== hdl/rlc_front.sv =====
`timescale 1ns / 1ps

module rlc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rlc_pkg::request_t request,
	output logic              job_valid,
	input  logic              job_take,
	output rlc_pkg::job_t     job
);

	rlc_pkg::job_t  fifo_q [2];
	rlc_pkg::job_t  job_new;
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	// decode request into an operation
	always_comb begin
		job_new.payload = request.payload;
		job_new.now_ms  = request.now_ms;
		if (request.kind == rlc_pkg::KIND_TICK) begin
			job_new.op = rlc_pkg::OP_TICK;
		end else begin
			case (request.command_code)
				rlc_pkg::CMD_TOGGLE:  job_new.op = rlc_pkg::OP_TOGGLE;
				rlc_pkg::CMD_ON:      job_new.op = rlc_pkg::OP_ON;
				rlc_pkg::CMD_OFF:     job_new.op = rlc_pkg::OP_OFF;
				rlc_pkg::CMD_HUE:     job_new.op = rlc_pkg::OP_HUE;
				rlc_pkg::CMD_SAT:     job_new.op = rlc_pkg::OP_SAT;
				rlc_pkg::CMD_VAL:     job_new.op = rlc_pkg::OP_VAL;
				rlc_pkg::CMD_RED:     job_new.op = rlc_pkg::OP_RED;
				rlc_pkg::CMD_GREEN:   job_new.op = rlc_pkg::OP_GREEN;
				rlc_pkg::CMD_BLUE:    job_new.op = rlc_pkg::OP_BLUE;
				rlc_pkg::CMD_WBRIGHT: job_new.op = rlc_pkg::OP_WBRIGHT;
				rlc_pkg::CMD_WRATIO:  job_new.op = rlc_pkg::OP_WRATIO;
				default:              job_new.op = rlc_pkg::OP_INVALID;
			endcase
		end
	end

	assign full      = cnt_q[1];
	assign job_valid = (cnt_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = job_take && job_valid;

	// two-entry queue between front and back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= job_new;
		end
	end

endmodule

// ===== hdl/rlc_back.sv =====
`timescale 1ns / 1ps

module rlc_back #(
	parameter int HB_MS = 3000,
	parameter int F     = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rlc_pkg::cfg_t    cfg,
	input  logic             job_valid,
	output logic             job_take,
	input  rlc_pkg::job_t    job,
	output logic             res_valid,
	input  logic             res_pop,
	output rlc_pkg::result_t res
);

	localparam int OPW = (F + 7 > 25) ? F + 7 : 25;
	localparam int HUW = (F + 9 > 25) ? F + 9 : 25;
	localparam int HW  = (OPW + 1) / 2;
	localparam int PW  = 2 * OPW;
	localparam int QW  = F + 6;
	localparam int KSH = QW + 6;

	localparam logic [OPW-1:0] ONE_FX   = OPW'(1) << F;
	localparam logic [OPW-1:0] SIXTY_FX = OPW'(60) << F;
	localparam logic [HUW-1:0] SIXTY_H  = HUW'(60) << F;
	localparam logic [HUW-1:0] H120_FX  = HUW'(120) << F;
	localparam logic [HUW-1:0] H360_FX  = HUW'(360) << F;
	localparam logic [31:0]    HB_PER   = 32'(HB_MS);
	// ceil(2^KSH / 60): exact floor(n / 60) for any n below 2^QW
	localparam logic [OPW-1:0] RECIP60  =
		OPW'(((64'd1 << KSH) + 64'd59) / 64'd60);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_HCHK, S_MUL_LO, S_MUL_HI, S_HC, S_HMOD, S_HX, S_HQ,
		S_HRGB, S_TICK_HB, S_COOL, S_WARM, S_DONE
	} state_t;

	state_t           state_q, ret_q;
	rlc_pkg::job_t    job_q;
	rlc_pkg::result_t out_q, res_q, done_res;
	logic             res_valid_q;

	// lamp state
	logic             light_on_q, pending_q;
	logic [31:0]      lct_q, lhb_q;
	logic [24:0]      hue_q, sat_q, val_q, wb_q, wr_q;
	logic [7:0]       red_q, green_q, blue_q;

	// shared multiplier and conversion working registers
	logic [OPW-1:0]   mul_a_q, mul_b_q;
	logic [PW-1:0]    acc_q;
	logic [F:0]       c_q, m_q;
	logic [HUW-1:0]   t_q;
	logic [1:0]       k_q;
	logic [2:0]       sec_q;

	logic [HW-1:0]     b_part;
	logic [OPW+HW-1:0] pp;
	logic [HUW-1:0]    d_val;
	logic [24:0]       col_int;
	logic [7:0]        col_arg;
	logic              auto_off, hb_due;
	logic [F:0]        x_val, r_ch, g_ch, b_ch;

	function automatic logic [7:0] level_of(input logic [F:0] v);
		logic [F+8:0] w;
		w = {v, 8'd0} - (F+9)'(v);
		return w[F +: 8];
	endfunction

	function automatic logic [15:0] duty_of(input logic [7:0] l);
		return (l == 8'hFF) ? 16'hFFFF : {l, 8'd0};
	endfunction

	function automatic logic [15:0] white_of(input logic [PW-1:0] p);
		logic [2*F+15:0] w;
		w = {p[2*F-1:0], 16'd0} - (2*F+16)'(p[2*F-1:0]);
		return (|p[PW-1:2*F]) ? 16'hFFFF : w[2*F +: 16];
	endfunction

	// half-width partial product
	assign b_part = (state_q == S_MUL_HI) ? HW'(mul_b_q >> HW) : mul_b_q[HW-1:0];
	assign pp     = (OPW+HW)'(mul_a_q) * (OPW+HW)'(b_part);

	assign d_val   = (t_q >= SIXTY_H) ? (t_q - SIXTY_H) : (SIXTY_H - t_q);
	assign col_int = job_q.payload >> F;
	assign col_arg = (col_int > 25'd255) ? 8'hFF : col_int[7:0];

	assign auto_off = !pending_q && light_on_q && (cfg.auto_off_ms != 32'd0) &&
		((lct_q + cfg.auto_off_ms) < job_q.now_ms);
	assign hb_due = cfg.heartbeat_enable && light_on_q &&
		((lhb_q + HB_PER) < job_q.now_ms);

	// sector select; X is the reciprocal product shifted down
	always_comb begin
		x_val = acc_q[KSH +: F+1];
		case (sec_q)
			3'd0:    begin r_ch = c_q;   g_ch = x_val; b_ch = '0;    end
			3'd1:    begin r_ch = x_val; g_ch = c_q;   b_ch = '0;    end
			3'd2:    begin r_ch = '0;    g_ch = c_q;   b_ch = x_val; end
			3'd3:    begin r_ch = '0;    g_ch = x_val; b_ch = c_q;   end
			3'd4:    begin r_ch = x_val; g_ch = '0;    b_ch = c_q;   end
			default: begin r_ch = c_q;   g_ch = '0;    b_ch = x_val; end
		endcase
	end

	// finished result with the final on state
	always_comb begin
		done_res         = out_q;
		done_res.lamp_on = light_on_q;
	end

	assign job_take  = (state_q == S_IDLE) && job_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			res_valid_q <= 1'b0;
			light_on_q  <= 1'b0;
			pending_q   <= 1'b0;
			lct_q       <= '0;
			lhb_q       <= '0;
			hue_q       <= '0;
			sat_q       <= '0;
			val_q       <= '0;
			wb_q        <= '0;
			wr_q        <= '0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
		end else begin
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						out_q   <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (job_q.op)
						rlc_pkg::OP_TOGGLE: begin
							light_on_q <= !light_on_q;
							pending_q  <= 1'b1;
						end
						rlc_pkg::OP_ON: begin
							if (!light_on_q) begin
								light_on_q <= 1'b1;
								pending_q  <= 1'b1;
							end
						end
						rlc_pkg::OP_OFF: begin
							if (light_on_q) begin
								light_on_q <= 1'b0;
								pending_q  <= 1'b1;
							end
						end
						rlc_pkg::OP_HUE: begin
							hue_q <= job_q.payload; pending_q <= 1'b1; state_q <= S_HCHK;
						end
						rlc_pkg::OP_SAT: begin
							sat_q <= job_q.payload; pending_q <= 1'b1; state_q <= S_HCHK;
						end
						rlc_pkg::OP_VAL: begin
							val_q <= job_q.payload; pending_q <= 1'b1; state_q <= S_HCHK;
						end
						rlc_pkg::OP_RED: begin
							red_q <= col_arg; pending_q <= 1'b1;
						end
						rlc_pkg::OP_GREEN: begin
							green_q <= col_arg; pending_q <= 1'b1;
						end
						rlc_pkg::OP_BLUE: begin
							blue_q <= col_arg; pending_q <= 1'b1;
						end
						rlc_pkg::OP_WBRIGHT: begin
							wb_q <= job_q.payload; pending_q <= 1'b1;
						end
						rlc_pkg::OP_WRATIO: begin
							wr_q <= job_q.payload; pending_q <= 1'b1;
						end
						rlc_pkg::OP_TICK: begin
							// auto-off step
							if (auto_off) begin
								pending_q  <= 1'b1;
								light_on_q <= 1'b0;
							end
							state_q <= S_TICK_HB;
						end
						default: out_q.status <= 1'b1;
					endcase
				end
				// HSV range check, then C = s*v
				S_HCHK: begin
					t_q <= HUW'(hue_q);
					k_q <= 2'd0;
					if ((HUW'(hue_q) > H360_FX) || (OPW'(sat_q) > ONE_FX) ||
						(OPW'(val_q) > ONE_FX)) begin
						state_q <= S_DONE;
					end else begin
						mul_a_q <= OPW'(sat_q);
						mul_b_q <= OPW'(val_q);
						ret_q   <= S_HC;
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					acc_q   <= PW'(pp);
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					acc_q   <= acc_q + (PW'(pp) << HW);
					state_q <= ret_q;
				end
				S_HC: begin
					c_q     <= acc_q[F +: F+1];
					m_q     <= val_q[F:0] - acc_q[F +: F+1];
					state_q <= S_HMOD;
				end
				// hue mod 120 by repeated subtraction
				S_HMOD: begin
					if (t_q >= H120_FX) begin
						t_q <= t_q - H120_FX;
						k_q <= k_q + 2'd1;
					end else begin
						state_q <= S_HX;
					end
				end
				S_HX: begin
					sec_q   <= {k_q, (t_q >= SIXTY_H)};
					mul_a_q <= OPW'(c_q);
					mul_b_q <= SIXTY_FX - OPW'(d_val);
					ret_q   <= S_HQ;
					state_q <= S_MUL_LO;
				end
				// divide by sixty through the reciprocal product
				S_HQ: begin
					mul_a_q <= OPW'(acc_q[F +: QW]);
					mul_b_q <= RECIP60;
					ret_q   <= S_HRGB;
					state_q <= S_MUL_LO;
				end
				S_HRGB: begin
					red_q   <= level_of(r_ch + m_q);
					green_q <= level_of(g_ch + m_q);
					blue_q  <= level_of(b_ch + m_q);
					state_q <= S_DONE;
				end
				// heartbeat and update steps of a tick
				S_TICK_HB: begin
					state_q <= S_DONE;
					if (hb_due) begin
						out_q.heartbeat <= 1'b1;
						lhb_q           <= job_q.now_ms;
					end
					if (pending_q) begin
						pending_q          <= 1'b0;
						lct_q              <= job_q.now_ms;
						out_q.update_valid <= 1'b1;
						if (light_on_q) begin
							out_q.red_duty   <= duty_of(red_q);
							out_q.green_duty <= duty_of(green_q);
							out_q.blue_duty  <= duty_of(blue_q);
							mul_a_q          <= OPW'(wb_q);
							mul_b_q          <= OPW'(wr_q);
							ret_q            <= S_COOL;
							state_q          <= S_MUL_LO;
						end
					end
				end
				S_COOL: begin
					out_q.cool_duty <= white_of(acc_q);
					mul_b_q         <= ONE_FX - OPW'(wr_q);
					ret_q           <= S_WARM;
					if (OPW'(wr_q) >= ONE_FX) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL_LO;
					end
				end
				S_WARM: begin
					out_q.warm_duty <= white_of(acc_q);
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q) begin
						res_q       <= done_res;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/tb_rgbw_light_controller.sv =====
`timescale 1ns / 1ps

module tb_rgbw_light_controller;

	localparam int HB_PERIOD = 3000;
	localparam int FB = 16;
	localparam longint ONE = 64'd1 << FB;
	localparam longint SIXTY = 64'd60 << FB;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	rlc_pkg::request_t request = '0;
	logic empty;
	logic pop = 1'b0;
	rlc_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_wdata = '0;

	rgbw_light_controller dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// lamp state mirror
	logic [31:0] m_auto_off;
	logic m_hb_en;
	logic m_on, m_pending;
	logic [31:0] m_last_change, m_last_hb;
	logic [24:0] m_hue, m_sat, m_val, m_white_b, m_white_r;
	logic [7:0] m_red, m_green, m_blue;

	rlc_pkg::request_t pending_requests[$];
	rlc_pkg::result_t lamp_results[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0, recv_idle = 0;
	int recv_hold = 0;
	bit hold_start = 1'b0;
	bit took = 1'b0;
	bit drain_pause = 1'b0;

	function automatic logic [15:0] level_duty(logic [7:0] lvl);
		return (lvl == 8'd255) ? 16'hFFFF : {lvl, 8'h00};
	endfunction

	function automatic logic [15:0] white_duty(longint unsigned b, longint unsigned fr);
		longint unsigned prod;
		prod = b * fr;
		if (prod >= (64'd1 << (2 * FB)))
			return 16'hFFFF;
		return 16'((prod * 65535) >> (2 * FB));
	endfunction

	task automatic hsv_to_rgb();
		longint unsigned h, s, v, c, x, m, t, d, r, g, b;
		h = m_hue;
		s = m_sat;
		v = m_val;
		if (h > 6 * SIXTY || s > ONE || v > ONE)
			return;
		c = (s * v) >> FB;
		m = v - c;
		t = h % (2 * SIXTY);
		d = (t >= SIXTY) ? t - SIXTY : SIXTY - t;
		x = (c * (SIXTY - d)) / SIXTY;
		if (h < SIXTY) begin
			r = c; g = x; b = 0;
		end else if (h < 2 * SIXTY) begin
			r = x; g = c; b = 0;
		end else if (h < 3 * SIXTY) begin
			r = 0; g = c; b = x;
		end else if (h < 4 * SIXTY) begin
			r = 0; g = x; b = c;
		end else if (h < 5 * SIXTY) begin
			r = x; g = 0; b = c;
		end else begin
			r = c; g = 0; b = x;
		end
		m_red = 8'(((r + m) * 255) >> FB);
		m_green = 8'(((g + m) * 255) >> FB);
		m_blue = 8'(((b + m) * 255) >> FB);
	endtask

	function automatic logic [7:0] colour_level(logic [24:0] p);
		return (p[24:FB] > 255) ? 8'd255 : 8'(p[24:FB]);
	endfunction

	// append one request to the driver queue
	task automatic add_request(input rlc_pkg::request_t rq);
		pending_requests.insert(pending_requests.size(), rq);
	endtask

	// compute the expected result of one request and advance the mirror
	task automatic predict_lamp(input rlc_pkg::request_t rq);
		rlc_pkg::result_t res;
		res = '0;
		if (rq.kind != rlc_pkg::KIND_TICK) begin
			case (rq.command_code)
				rlc_pkg::CMD_TOGGLE: begin
					m_on = !m_on; m_pending = 1'b1;
				end
				rlc_pkg::CMD_ON: if (!m_on) begin
					m_on = 1'b1; m_pending = 1'b1;
				end
				rlc_pkg::CMD_OFF: if (m_on) begin
					m_on = 1'b0; m_pending = 1'b1;
				end
				rlc_pkg::CMD_HUE: begin
					m_hue = rq.payload; hsv_to_rgb(); m_pending = 1'b1;
				end
				rlc_pkg::CMD_SAT: begin
					m_sat = rq.payload; hsv_to_rgb(); m_pending = 1'b1;
				end
				rlc_pkg::CMD_VAL: begin
					m_val = rq.payload; hsv_to_rgb(); m_pending = 1'b1;
				end
				rlc_pkg::CMD_RED: begin
					m_red = colour_level(rq.payload); m_pending = 1'b1;
				end
				rlc_pkg::CMD_GREEN: begin
					m_green = colour_level(rq.payload); m_pending = 1'b1;
				end
				rlc_pkg::CMD_BLUE: begin
					m_blue = colour_level(rq.payload); m_pending = 1'b1;
				end
				rlc_pkg::CMD_WBRIGHT: begin
					m_white_b = rq.payload; m_pending = 1'b1;
				end
				rlc_pkg::CMD_WRATIO: begin
					m_white_r = rq.payload; m_pending = 1'b1;
				end
				default: res.status = 1'b1;
			endcase
		end else begin
			if (!m_pending && m_on && m_auto_off != 0 &&
					32'(m_last_change + m_auto_off) < rq.now_ms) begin
				m_pending = 1'b1;
				m_on = 1'b0;
			end
			if (m_hb_en && m_on && 32'(m_last_hb + HB_PERIOD) < rq.now_ms) begin
				res.heartbeat = 1'b1;
				m_last_hb = rq.now_ms;
			end
			if (m_pending) begin
				m_pending = 1'b0;
				m_last_change = rq.now_ms;
				res.update_valid = 1'b1;
				if (m_on) begin
					res.red_duty = level_duty(m_red);
					res.green_duty = level_duty(m_green);
					res.blue_duty = level_duty(m_blue);
					res.cool_duty = white_duty(m_white_b, m_white_r);
					res.warm_duty = (m_white_r >= ONE) ? 16'd0 :
						white_duty(m_white_b, ONE - m_white_r);
				end
			end
		end
		res.lamp_on = m_on;
		lamp_results.insert(lamp_results.size(), res);
	endtask

	// long receive stall, counted here
	always @(negedge clk) begin
		if (hold_start)
			recv_hold <= 300;
		else if (recv_hold > 0)
			recv_hold <= recv_hold - 1;
	end

	// driver: offer requests at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (took)
				void'(pending_requests.pop_front());
			if (pending_requests.size() > (took ? 1 : 0) && !drain_pause &&
					$urandom_range(99) >= send_idle) begin
				push <= 1'b1;
				request <= took ? pending_requests[1] : pending_requests[0];
			end else begin
				push <= 1'b0;
			end
			if (recv_hold > 0) begin
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		took <= arst_n && push && !full;
		if (arst_n && push && !full)
			predict_lamp(request);
		if (arst_n && pop && !empty) begin
			if (lamp_results.size() == 0) begin
				$error("unexpected result %p", result);
				errors++;
			end else begin
				rlc_pkg::result_t e;
				e = lamp_results.pop_front();
				if (result.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, result.status); errors++;
				end
				if (result.update_valid !== e.update_valid) begin
					$error("update_valid exp %0d got %0d", e.update_valid,
						result.update_valid); errors++;
				end
				if (result.red_duty !== e.red_duty) begin
					$error("red_duty exp %0d got %0d", e.red_duty, result.red_duty); errors++;
				end
				if (result.green_duty !== e.green_duty) begin
					$error("green_duty exp %0d got %0d", e.green_duty, result.green_duty);
					errors++;
				end
				if (result.blue_duty !== e.blue_duty) begin
					$error("blue_duty exp %0d got %0d", e.blue_duty, result.blue_duty);
					errors++;
				end
				if (result.cool_duty !== e.cool_duty) begin
					$error("cool_duty exp %0d got %0d", e.cool_duty, result.cool_duty);
					errors++;
				end
				if (result.warm_duty !== e.warm_duty) begin
					$error("warm_duty exp %0d got %0d", e.warm_duty, result.warm_duty);
					errors++;
				end
				if (result.heartbeat !== e.heartbeat) begin
					$error("heartbeat exp %0d got %0d", e.heartbeat, result.heartbeat);
					errors++;
				end
				if (result.lamp_on !== e.lamp_on) begin
					$error("lamp_on exp %0d got %0d", e.lamp_on, result.lamp_on); errors++;
				end
			end
		end
	end

	function automatic rlc_pkg::request_t make_request(logic k, logic [3:0] code,
			logic [24:0] p, logic [31:0] t);
		rlc_pkg::request_t rq;
		rq.kind = k;
		rq.command_code = code;
		rq.payload = p;
		rq.now_ms = t;
		return rq;
	endfunction

	// wait for all requests to be taken and all results checked
	task automatic wait_drained();
		while (pending_requests.size() > 0 || push || lamp_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rlc_pkg::REG_AUTO_OFF)
			m_auto_off = val;
		else
			m_hb_en = val[0];
	endtask

	// random payload: mostly in-range fractions or colour values, some wide
	function automatic logic [24:0] rand_payload(logic [3:0] code);
		case ($urandom_range(3))
			0: return 25'($urandom);
			1: return 25'($urandom_range(32'(ONE)));
			2: return (code == rlc_pkg::CMD_HUE) ? 25'($urandom_range(32'(6 * SIXTY)))
				: 25'($urandom_range(32'(ONE)));
			default: return 25'($urandom_range(300) << FB);
		endcase
	endfunction

	// one phase: a mix of commands and advancing ticks
	task automatic queue_random(int n, inout logic [31:0] clock_ms);
		rlc_pkg::request_t rq;
		logic [3:0] code;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(2) == 0) begin
				clock_ms += $urandom_range(4000);
				if ($urandom_range(30) == 0)
					clock_ms = $urandom;
				rq = make_request(rlc_pkg::KIND_TICK, 4'($urandom), 25'($urandom), clock_ms);
			end else begin
				code = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 11))
					: 4'($urandom_range(10));
				rq = make_request(1'b1, code, rand_payload(code), $urandom);
			end
			add_request(rq);
		end
	endtask

	initial begin
		logic [31:0] clock_ms;
		m_auto_off = 0; m_hb_en = 0; m_on = 0; m_pending = 0;
		m_last_change = 0; m_last_hb = 0; m_hue = 0; m_sat = 0; m_val = 0;
		m_white_b = 0; m_white_r = 0; m_red = 0; m_green = 0; m_blue = 0;
		clock_ms = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_reg(rlc_pkg::REG_AUTO_OFF, 32'd5000);
		write_reg(rlc_pkg::REG_HEARTBEAT, 32'd1);

		// directed: extremes, every command, invalid codes, out-of-range hsv
		add_request(make_request(1'b1, rlc_pkg::CMD_ON, 25'd0, 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_ON, 25'd0, 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_SAT, 25'(ONE), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_VAL, 25'(ONE), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_HUE, 25'(6 * SIXTY), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_HUE, 25'(6 * SIXTY + 1), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_HUE, 25'(SIXTY), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_SAT, 25'(ONE + 1), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_WBRIGHT, 25'h1FFFFFF, 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_WRATIO, 25'(ONE / 2), 32'd0));
		add_request(make_request(rlc_pkg::KIND_TICK, 4'hF, 25'h1FFFFFF, 32'd3001));
		add_request(make_request(1'b1, rlc_pkg::CMD_RED, 25'h1FFFFFF, 32'hFFFFFFFF));
		add_request(make_request(1'b1, rlc_pkg::CMD_GREEN, 25'(255 << FB), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_BLUE, 25'(254 << FB), 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_WRATIO, 25'(ONE), 32'd0));
		add_request(make_request(rlc_pkg::KIND_TICK, 4'd0, 25'd0, 32'd4000));
		add_request(make_request(1'b1, rlc_pkg::CMD_WRATIO, 25'd0, 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_TOGGLE, 25'd0, 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_OFF, 25'd0, 32'd0));
		add_request(make_request(1'b1, rlc_pkg::CMD_TOGGLE, 25'd0, 32'd0));
		add_request(make_request(rlc_pkg::KIND_TICK, 4'd0, 25'd0, 32'd5000));
		add_request(make_request(rlc_pkg::KIND_TICK, 4'd0, 25'd0, 32'hFFFFFFFF));
		add_request(make_request(1'b1, 4'd11, 25'd0, 32'd0));
		add_request(make_request(1'b1, 4'd15, 25'h1FFFFFF, 32'd0));
		clock_ms = 32'hFFFFFFFF;
		wait_drained();

		// random phases with changing idle pressure and settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 79; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 79; end
				default: begin send_idle = 7; recv_idle = 7; end
			endcase
			case (ph)
				1: write_reg(rlc_pkg::REG_AUTO_OFF, 32'd0);
				2: write_reg(rlc_pkg::REG_AUTO_OFF, 32'hFFFFFFFF);
				3: write_reg(rlc_pkg::REG_HEARTBEAT, 32'd0);
				4: write_reg(rlc_pkg::REG_AUTO_OFF, $urandom_range(8000, 1));
				5: write_reg(rlc_pkg::REG_HEARTBEAT, 32'hFFFFFFFF);
				6: write_reg(rlc_pkg::REG_AUTO_OFF, 32'd1);
				default: ;
			endcase
			if (ph == 4) begin
				// long receive stall while requests keep arriving
				@(posedge clk);
				hold_start = 1'b1;
				@(posedge clk);
				hold_start = 1'b0;
			end
			queue_random(135, clock_ms);
			if (ph == 5) begin
				// sender pauses until all results are back
				while (pending_requests.size() > 60)
					@(posedge clk);
				@(negedge clk);
				drain_pause = 1'b1;
				while (push || lamp_results.size() > 0)
					@(posedge clk);
				@(negedge clk);
				drain_pause = 1'b0;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
